>>> rtl/assert_macros.svh
// Assertion macros shared by the affine transform RTL.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/aff2d_pkg.sv
// Package for the affine transform unit: payload structs, opcodes, FSM states,
// datapath command and status structs. No dependencies.
`default_nettype none
package aff2d_pkg;
	localparam int FracBitsDefault = 16;
	localparam int QW = 32;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_COMPOSE = 2'd1,
		OP_INVERT  = 2'd2,
		OP_POINT   = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic signed [31:0] in_a;
		logic signed [31:0] in_b;
		logic signed [31:0] in_c;
		logic signed [31:0] in_d;
		logic signed [31:0] in_e;
		logic signed [31:0] in_f;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               singular;
		logic               saturated;
	} out_item_t;

	// Datapath micro-operations
	typedef enum logic [3:0] {
		UOP_NONE,
		UOP_LOAD,     // capture item, load matrix if op is load
		UOP_MUL,      // acc (+)= floor(mul_a*mul_b / 2^FRAC_BITS), term selected by step
		UOP_ADDC,     // acc += translation: operand c/f, or matrix m02/m12 when step[1]
		UOP_SAT,      // saturate acc into temp slot
		UOP_DET,      // det step
		UOP_DIVINIT,  // start division of numerator selected by step
		UOP_DIVSTEP,  // one restoring division step
		UOP_DIVFIN,   // finish quotient into temp slot
		UOP_COMMIT,   // temp -> matrix
		UOP_POINT,    // temp slots -> out point (not decoded; result reads t0/t1 directly)
		UOP_FLAGS     // recompute singular flag
	} uop_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_FLAG,
		ST_OUT
	} state_t;

	typedef struct packed {
		uop_t       uop;
		logic [4:0] step;
		logic       clr;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic det_zero;
		logic div_done;
	} dp_sts_t;
endpackage
`default_nettype wire

>>> rtl/aff2d_datapath.sv
// Datapath: matrix registers, one shared 33x33 multiplier with accumulator,
// a one-bit-per-cycle restoring divider. Depends on aff2d_pkg.
`default_nettype none
module aff2d_datapath #(
	parameter int FRAC_BITS = aff2d_pkg::FracBitsDefault
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  aff2d_pkg::in_item_t  item,
	input  aff2d_pkg::dp_cmd_t   cmd,
	output aff2d_pkg::dp_sts_t   sts,
	output aff2d_pkg::out_item_t result
);
	import aff2d_pkg::*;

	localparam int DW = 2 * FRAC_BITS + 66;    // dividend bits (|num| <= 2^32)
	localparam int CW = $clog2(DW + 1);
	localparam logic [63:0] QCAP = 64'd1 << 40;

	logic signed [31:0] m_q [6];
	logic signed [31:0] t_q [6];
	in_item_t           it_q;
	logic signed [65:0] acc_q;   // exact sums up to three 64-bit terms
	logic signed [65:0] det_q;
	logic               sat_q;
	logic               zero_q;

	// division
	logic [DW-1:0]  dvd_q;
	logic [65:0]    rem_q;
	logic [65:0]    dsr_q;
	logic [63:0]    quo_q;
	logic           big_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;

	// operand selection for multiplier
	logic signed [32:0] mul_a, mul_b;
	logic [2:0]         slot;
	logic signed [32:0] num;
	logic signed [65:0] addc;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic is_sat(input logic signed [65:0] v);
		return (v > 66'sd2147483647) || (v < -66'sd2147483648);
	endfunction

	// Step encoding: step selects the UOP_MUL/UOP_DET operand pair, step[2:0] the temp slot, step[1:0] num and addc
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		slot  = cmd.step[2:0];
		num   = '0;
		addc  = '0;
		case (cmd.step)
			// compose: n[r][c] = a_r*m0c + b_r*m1c
			5'd0:  begin mul_a = 33'(it_q.in_a); mul_b = 33'(m_q[0]); end
			5'd1:  begin mul_a = 33'(it_q.in_b); mul_b = 33'(m_q[3]); end
			5'd2:  begin mul_a = 33'(it_q.in_a); mul_b = 33'(m_q[1]); end
			5'd3:  begin mul_a = 33'(it_q.in_b); mul_b = 33'(m_q[4]); end
			5'd4:  begin mul_a = 33'(it_q.in_a); mul_b = 33'(m_q[2]); end
			5'd5:  begin mul_a = 33'(it_q.in_b); mul_b = 33'(m_q[5]); end
			5'd6:  begin mul_a = 33'(it_q.in_d); mul_b = 33'(m_q[0]); end
			5'd7:  begin mul_a = 33'(it_q.in_e); mul_b = 33'(m_q[3]); end
			5'd8:  begin mul_a = 33'(it_q.in_d); mul_b = 33'(m_q[1]); end
			5'd9:  begin mul_a = 33'(it_q.in_e); mul_b = 33'(m_q[4]); end
			5'd10: begin mul_a = 33'(it_q.in_d); mul_b = 33'(m_q[2]); end
			5'd11: begin mul_a = 33'(it_q.in_e); mul_b = 33'(m_q[5]); end
			// point
			5'd12: begin mul_a = 33'(m_q[0]); mul_b = 33'(it_q.in_x); end
			5'd13: begin mul_a = 33'(m_q[1]); mul_b = 33'(it_q.in_y); end
			5'd14: begin mul_a = 33'(m_q[3]); mul_b = 33'(it_q.in_x); end
			5'd15: begin mul_a = 33'(m_q[4]); mul_b = 33'(it_q.in_y); end
			// invert translations, t0,t1,t3,t4 hold i00,i01,i10,i11
			5'd16: begin mul_a = -33'(m_q[2]); mul_b = 33'(t_q[0]); end
			5'd17: begin mul_a = -33'(m_q[5]); mul_b = 33'(t_q[1]); end
			5'd18: begin mul_a = -33'(m_q[2]); mul_b = 33'(t_q[3]); end
			5'd19: begin mul_a = -33'(m_q[5]); mul_b = 33'(t_q[4]); end
			// determinant
			5'd20: begin mul_a = 33'(m_q[0]); mul_b = 33'(m_q[4]); end
			5'd21: begin mul_a = 33'(m_q[3]); mul_b = 33'(m_q[1]); end
			default: ;
		endcase
		case (cmd.step[1:0])
			2'd0: num = 33'(m_q[4]);
			2'd1: num = -33'(m_q[1]);
			2'd2: num = -33'(m_q[3]);
			default: num = 33'(m_q[0]);
		endcase
		case (cmd.step[1:0])
			2'd0: addc = 66'(it_q.in_c);
			2'd1: addc = 66'(it_q.in_f);
			2'd2: addc = 66'(m_q[2]);
			default: addc = 66'(m_q[5]);
		endcase
	end

	logic signed [65:0] pfull;
	logic signed [65:0] pfl;
	assign pfull = 66'(mul_a) * 66'(mul_b);
	assign pfl   = pfull >>> FRAC_BITS;   // arithmetic shift floors

	logic [65:0] rem_sh;
	logic        rem_ge;
	assign rem_sh = {rem_q[64:0], dvd_q[DW-1]};
	assign rem_ge = rem_sh >= dsr_q;

	logic [63:0] q_next;
	always_comb begin
		q_next = big_q ? quo_q : {quo_q[62:0], rem_ge};
	end

	logic signed [64:0] qsig;
	assign qsig = neg_q ? -(65'(quo_q) + 65'(rem_q != '0)) : 65'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q[0] <= 32'sd1 <<< FRAC_BITS;
			m_q[1] <= '0;
			m_q[2] <= '0;
			m_q[3] <= '0;
			m_q[4] <= 32'sd1 <<< FRAC_BITS;
			m_q[5] <= '0;
			zero_q <= 1'b0;
		end else begin
			case (cmd.uop)
				UOP_LOAD: begin
					if (item.op == OP_LOAD) begin
						m_q[0] <= item.in_a; m_q[1] <= item.in_b; m_q[2] <= item.in_c;
						m_q[3] <= item.in_d; m_q[4] <= item.in_e; m_q[5] <= item.in_f;
					end
				end
				UOP_COMMIT: begin
					for (int i = 0; i < 6; i++) m_q[i] <= t_q[i];
				end
				UOP_FLAGS: zero_q <= (det_q == '0);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_LOAD: begin
				it_q  <= item;
				sat_q <= 1'b0;
				acc_q <= '0;
				for (int i = 0; i < 6; i++) t_q[i] <= '0;
			end
			UOP_MUL: acc_q <= (cmd.clr ? 66'sd0 : acc_q) + 66'(pfl);
			UOP_ADDC: acc_q <= acc_q + addc;
			UOP_SAT: begin
				t_q[slot] <= sat32(acc_q);
				sat_q <= sat_q | is_sat(acc_q);
			end
			UOP_DET: det_q <= (cmd.clr ? 66'(pfull) : det_q - pfull);
			UOP_DIVINIT: begin
				neg_q <= num[32] ^ det_q[65];
				dvd_q <= DW'(num[32] ? -num : num) << (2 * FRAC_BITS);
				dsr_q <= det_q[65] ? -det_q : det_q;
				rem_q <= '0;
				quo_q <= '0;
				big_q <= 1'b0;
				cnt_q <= '0;
			end
			UOP_DIVSTEP: begin
				rem_q <= rem_ge ? rem_sh - dsr_q : rem_sh;
				dvd_q <= dvd_q << 1;
				quo_q <= q_next;
				big_q <= big_q | (q_next >= QCAP);
				cnt_q <= cnt_q + 1'b1;
			end
			UOP_DIVFIN: begin
				if (big_q) begin
					t_q[slot] <= neg_q ? 32'sh80000000 : 32'sh7fffffff;
					sat_q <= 1'b1;
				end else begin
					t_q[slot] <= sat32(66'(qsig));
					sat_q <= sat_q | is_sat(66'(qsig));
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.op       = it_q.op;
		sts.det_zero = (det_q == '0);
		sts.div_done = (cnt_q == CW'(DW));
		result.out_x     = (it_q.op == OP_POINT) ? t_q[0] : '0;
		result.out_y     = (it_q.op == OP_POINT) ? t_q[1] : '0;
		result.singular  = zero_q;
		result.saturated = sat_q;
	end

	`include "assert_macros.svh"
	`ASSERT_NEXT(a_div_cnt, clk, arst_n, cmd.uop == UOP_DIVINIT, cnt_q == '0)
	`ASSERT_NEXT(a_load_clr, clk, arst_n, cmd.uop == UOP_LOAD, sat_q == 1'b0)
	`ASSERT_NEXT(a_big_sat, clk, arst_n, cmd.uop == UOP_DIVFIN && big_q, sat_q)
endmodule
`default_nettype wire

>>> rtl/aff2d_ctrl.sv
// Controller: sequences datapath micro-operations for each opcode.
// Depends on aff2d_pkg.
`default_nettype none
module aff2d_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_fire,
	input  wire                out_fire,
	input  aff2d_pkg::dp_sts_t sts,
	output aff2d_pkg::dp_cmd_t cmd,
	output logic               busy,
	output logic               out_valid
);
	import aff2d_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] pc_q, pc_d;   // micro-program counter

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	// Micro-programs, indexed by pc.
	// compose: per entry k (0..5): MUL clr, MUL, [ADDC], SAT
	// invert : DET x2, check, then per quotient: DIVINIT, DIVSTEPs, DIVFIN;
	//          then translations, COMMIT.
	// point  : per row: MUL clr, MUL, ADDC of the matrix translation, SAT.
	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		cmd.uop   = UOP_NONE;
		cmd.step  = '0;
		cmd.clr   = 1'b0;
		busy      = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.uop = UOP_LOAD;
					pc_d    = '0;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				case (sts.op)
					OP_LOAD: state_d = ST_FLAG;
					OP_COMPOSE: begin
						// pc: entry = pc[4:2], phase = pc[1:0]
						case (pc_q[1:0])
							2'd0: begin
								cmd.uop = UOP_MUL; cmd.clr = 1'b1;
								cmd.step = 5'(pc_q[4:2] * 2);
							end
							2'd1: begin
								cmd.uop = UOP_MUL;
								cmd.step = 5'(pc_q[4:2] * 2 + 1);
							end
							2'd2: begin
								if (pc_q[4:2] == 3'd2 || pc_q[4:2] == 3'd5) begin
									cmd.uop = UOP_ADDC;
									cmd.step = {4'd0, pc_q[4:2] == 3'd5};
								end
							end
							default: begin
								cmd.uop = UOP_SAT;
								cmd.step = {2'd0, pc_q[4:2]};
							end
						endcase
						pc_d = pc_q + 1'b1;
						if (pc_q == 6'd23) begin
							state_d = ST_FLAG;
							pc_d = '0;
						end
					end
					OP_POINT: begin
						// row r = pc[2]; phases MUL clr, MUL, ADD trans, SAT
						case (pc_q[1:0])
							2'd0: begin
								cmd.uop = UOP_MUL; cmd.clr = 1'b1;
								cmd.step = pc_q[2] ? 5'd14 : 5'd12;
							end
							2'd1: begin
								cmd.uop = UOP_MUL;
								cmd.step = pc_q[2] ? 5'd15 : 5'd13;
							end
							2'd2: begin
								cmd.uop = UOP_ADDC;
								cmd.step = {3'd0, 1'b1, pc_q[2]};
							end
							default: begin
								cmd.uop = UOP_SAT;
								cmd.step = {4'd0, pc_q[2]};
							end
						endcase
						pc_d = pc_q + 1'b1;
						if (pc_q == 6'd7) begin
							state_d = ST_FLAG;
							pc_d = '0;
						end
					end
					default: begin
						// invert
						case (pc_q)
							6'd0: begin cmd.uop = UOP_DET; cmd.clr = 1'b1; cmd.step = 5'd20; pc_d = 6'd1; end
							6'd1: begin cmd.uop = UOP_DET; cmd.step = 5'd21; pc_d = 6'd2; end
							6'd2: begin
								if (sts.det_zero) state_d = ST_FLAG;
								else pc_d = 6'd3;
							end
							6'd3, 6'd6, 6'd9, 6'd12: begin
								cmd.uop = UOP_DIVINIT;
								case (pc_q)
									6'd3: cmd.step = 5'd0;
									6'd6: cmd.step = 5'd1;
									6'd9: cmd.step = 5'd2;
									default: cmd.step = 5'd3;
								endcase
								pc_d = pc_q + 1'b1;
							end
							6'd4, 6'd7, 6'd10, 6'd13: begin
								cmd.uop = UOP_DIVSTEP;
								if (sts.div_done) begin
									cmd.uop = UOP_NONE;
									pc_d = pc_q + 1'b1;
								end
							end
							6'd5, 6'd8, 6'd11, 6'd14: begin
								// i00->t0, i01->t1, i10->t3, i11->t4
								cmd.uop = UOP_DIVFIN;
								case (pc_q)
									6'd5: cmd.step = 5'd0;
									6'd8: cmd.step = 5'd1;
									6'd11: cmd.step = 5'd3;
									default: cmd.step = 5'd4;
								endcase
								pc_d = pc_q + 1'b1;
							end
							6'd15: begin cmd.uop = UOP_MUL; cmd.clr = 1'b1; cmd.step = 5'd16; pc_d = 6'd16; end
							6'd16: begin cmd.uop = UOP_MUL; cmd.step = 5'd17; pc_d = 6'd17; end
							6'd17: begin cmd.uop = UOP_SAT; cmd.step = 5'd2; pc_d = 6'd18; end
							6'd18: begin cmd.uop = UOP_MUL; cmd.clr = 1'b1; cmd.step = 5'd18; pc_d = 6'd19; end
							6'd19: begin cmd.uop = UOP_MUL; cmd.step = 5'd19; pc_d = 6'd20; end
							6'd20: begin cmd.uop = UOP_SAT; cmd.step = 5'd5; pc_d = 6'd21; end
							default: begin cmd.uop = UOP_COMMIT; state_d = ST_FLAG; end
						endcase
					end
				endcase
			end
			ST_FLAG: begin
				// commit compose results, then determinant of the new matrix
				case (pc_q)
					6'd0: begin
						if (sts.op == OP_COMPOSE) cmd.uop = UOP_COMMIT;
						pc_d = 6'd1;
					end
					6'd1: begin cmd.uop = UOP_DET; cmd.clr = 1'b1; cmd.step = 5'd20; pc_d = 6'd2; end
					6'd2: begin cmd.uop = UOP_DET; cmd.step = 5'd21; pc_d = 6'd3; end
					default: begin cmd.uop = UOP_FLAGS; state_d = ST_OUT; pc_d = '0; end
				endcase
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_RUN && state_d == ST_FLAG) pc_d = '0;
	end

	`include "assert_macros.svh"
	`ASSERT_IMPLIES(a_in_idle, clk, arst_n, in_fire, state_q == ST_IDLE)
	`ASSERT_NEXT(a_out_done, clk, arst_n, out_fire, state_q == ST_IDLE)
	`ASSERT_IMPLIES(a_pc_range, clk, arst_n, state_q == ST_RUN, pc_q < 6'd24)
endmodule
`default_nettype wire

>>> rtl/affine_2d_transform_unit.sv
// Affine 2D transform unit, one item in flight; depends on aff2d_pkg, aff2d_ctrl, aff2d_datapath.
// An invert runs four serial divisions of 2*FRAC_BITS+66 steps each, one quotient bit per cycle;
// a singular invert skips the divisions.
// A new input is accepted only once the previous result has been taken at the output.
// Reset: arst_n asynchronously restores the identity matrix and idles control.
`default_nettype none
module affine_2d_transform_unit #(
	parameter int FRAC_BITS = aff2d_pkg::FracBitsDefault
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  aff2d_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output aff2d_pkg::out_item_t  out_data
);
	import aff2d_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    busy;
	logic    in_fire, out_fire;

	assign in_ready = !busy;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	aff2d_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
	);

	aff2d_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(in_data), .cmd(cmd), .sts(sts),
		.result(out_data)
	);
endmodule
`default_nettype wire

>>> verif/tb_affine_2d_transform_unit.sv
// Testbench for affine_2d_transform_unit: drives load, compose, invert and point
// operations through valid/ready, predicts each result in fixed point, checks it.
// Depends on aff2d_pkg and the affine_2d_transform_unit RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_affine_2d_transform_unit;
	import aff2d_pkg::*;

	localparam int FB = 16;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam int ONE = 1 << FB;
	localparam longint CYCLE_LIMIT = 6000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	affine_2d_transform_unit #(.FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model copy of the held matrix
	longint mat [6];
	bit clamp_hit;
	out_item_t expected_results[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int op_count [4];
	int sat_count = 0;
	int sing_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	longint cycles = 0;

	function automatic longint sat32(longint v);
		if (v > QMAX) begin
			clamp_hit = 1'b1;
			return QMAX;
		end
		if (v < QMIN) begin
			clamp_hit = 1'b1;
			return QMIN;
		end
		return v;
	endfunction

	// arithmetic shift floors toward minus infinity
	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> FB;
	endfunction

	function automatic longint det_of();
		return mat[0] * mat[4] - mat[3] * mat[1];
	endfunction

	// floor(num * 2^(2F) / det) with a quotient cap, then saturation
	function automatic longint qdiv(longint num, longint det);
		bit neg;
		logic [127:0] dividend;
		logic [127:0] divisor;
		logic [127:0] quo;
		logic [127:0] rem;
		longint v;
		neg = (num < 0) != (det < 0);
		dividend = 128'(num < 0 ? -num : num) << (2 * FB);
		divisor = 128'(det < 0 ? -det : det);
		quo = dividend / divisor;
		rem = dividend % divisor;
		if (quo >= (128'd1 << 40)) begin
			clamp_hit = 1'b1;
			return neg ? QMIN : QMAX;
		end
		v = longint'(quo[63:0]);
		if (neg) v = -(v + (rem != 0 ? 1 : 0));
		return sat32(v);
	endfunction

	function automatic out_item_t transform_step(in_item_t it);
		out_item_t r;
		longint a, b, c, d, e, f, x, y, det;
		longint n [6];
		a = it.in_a; b = it.in_b; c = it.in_c;
		d = it.in_d; e = it.in_e; f = it.in_f;
		x = it.in_x; y = it.in_y;
		clamp_hit = 1'b0;
		r = '0;
		case (it.op)
			OP_LOAD: begin
				mat = '{a, b, c, d, e, f};
			end
			OP_COMPOSE: begin
				n[0] = sat32(qmul(a, mat[0]) + qmul(b, mat[3]));
				n[1] = sat32(qmul(a, mat[1]) + qmul(b, mat[4]));
				n[2] = sat32(qmul(a, mat[2]) + qmul(b, mat[5]) + c);
				n[3] = sat32(qmul(d, mat[0]) + qmul(e, mat[3]));
				n[4] = sat32(qmul(d, mat[1]) + qmul(e, mat[4]));
				n[5] = sat32(qmul(d, mat[2]) + qmul(e, mat[5]) + f);
				mat = n;
			end
			OP_INVERT: begin
				det = det_of();
				if (det != 0) begin
					n[0] = qdiv(mat[4], det);
					n[1] = qdiv(-mat[1], det);
					n[3] = qdiv(-mat[3], det);
					n[4] = qdiv(mat[0], det);
					n[2] = sat32(qmul(-mat[2], n[0]) + qmul(-mat[5], n[1]));
					n[5] = sat32(qmul(-mat[2], n[3]) + qmul(-mat[5], n[4]));
					mat = n;
				end
			end
			default: begin
				r.out_x = 32'(sat32(qmul(mat[0], x) + qmul(mat[1], y) + mat[2]));
				r.out_y = 32'(sat32(qmul(mat[3], x) + qmul(mat[4], y) + mat[5]));
			end
		endcase
		r.singular = (det_of() == 0);
		r.saturated = clamp_hit;
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(in_item_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(transform_step(it));
		op_count[it.op]++;
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			2: return 32'($urandom_range(4 * ONE)) - 2 * ONE;
			3: return 32'($urandom_range(2000)) - 1000;
			default: return 32'($urandom_range(ONE / 2)) - ONE / 4 + ($urandom_range(1) ? ONE : 0);
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.op = pick < 15 ? OP_LOAD : pick < 40 ? OP_COMPOSE : pick < 55 ? OP_INVERT : OP_POINT;
		it.in_a = rand_q(); it.in_b = rand_q(); it.in_c = rand_q();
		it.in_d = rand_q(); it.in_e = rand_q(); it.in_f = rand_q();
		it.in_x = rand_q(); it.in_y = rand_q();
		if ($urandom_range(9) == 0) it.in_b = 0;
		if ($urandom_range(9) == 0) it.in_d = 0;
		return it;
	endfunction

	function automatic in_item_t mk(op_t op, int a, int b, int c, int d, int e, int f,
			int x, int y);
		in_item_t it;
		it.op = op;
		it.in_a = a; it.in_b = b; it.in_c = c; it.in_d = d; it.in_e = e; it.in_f = f;
		it.in_x = x; it.in_y = y;
		return it;
	endfunction

	// checker: one result per accepted output transfer
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				checked++;
				if (out_data.saturated) sat_count++;
				if (out_data.singular) sing_count++;
				if (out_data.out_x !== exp_r.out_x)
					$display("%0t: out_x expected %h actual %h", $time, exp_r.out_x,
						out_data.out_x);
				if (out_data.out_y !== exp_r.out_y)
					$display("%0t: out_y expected %h actual %h", $time, exp_r.out_y,
						out_data.out_y);
				if (out_data.singular !== exp_r.singular)
					$display("%0t: singular expected %b actual %b", $time, exp_r.singular,
						out_data.singular);
				if (out_data.saturated !== exp_r.saturated)
					$display("%0t: saturated expected %b actual %b", $time,
						exp_r.saturated, out_data.saturated);
				if (out_data !== exp_r) errors++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t, %0d results pending", $time, expected_results.size());
			$display("affine_2d_transform_unit verification failed");
			$finish;
		end
	end

	task automatic test_directed();
		int mx = 32'h7fffffff;
		int mn = 32'h80000000;
		send_item(mk(OP_POINT, 0, 0, 0, 0, 0, 0, 3 * ONE, -5 * ONE));
		send_item(mk(OP_POINT, 0, 0, 0, 0, 0, 0, mx, mn));
		send_item(mk(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_LOAD, 2 * ONE, ONE, 7, -ONE, 3 * ONE, -9, 0, 0));
		send_item(mk(OP_POINT, 0, 0, 0, 0, 0, 0, -1, 1));
		send_item(mk(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_POINT, 0, 0, 0, 0, 0, 0, ONE + 3, -ONE / 3));
		send_item(mk(OP_COMPOSE, 0, -ONE, ONE, ONE, 0, -ONE, 0, 0));
		send_item(mk(OP_COMPOSE, mx, mx, mx, mn, mn, mn, 0, 0));
		send_item(mk(OP_POINT, 0, 0, 0, 0, 0, 0, mx, mx));
		send_item(mk(OP_LOAD, ONE, 2 * ONE, 0, ONE, 2 * ONE, 0, 0, 0));
		send_item(mk(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_LOAD, 1, 0, mx, 0, 1, mn, 0, 0));
		send_item(mk(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_LOAD, mn, 0, 0, 0, mn, 0, 0, 0));
		send_item(mk(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_LOAD, mx, mn, -1, -1, mx, 1, 0, 0));
		send_item(mk(OP_POINT, 0, 0, 0, 0, 0, 0, mn, mx));
		send_item(mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_COMPOSE, ONE, 0, 0, 0, ONE, 0, 0, 0));
		send_item(mk(OP_LOAD, ONE, 0, 0, 0, ONE, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) send_item(rand_item());
		wait_drained();
	endtask

	// receiver blocked while the sender keeps offering
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (8) send_item(rand_item());
		join
		wait_drained();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i < 6; i++) mat[i] = 0;
		mat[0] = ONE;
		mat[4] = ONE;
		test_directed();
		test_random(800, 0, 0);
		test_backpressure();
		test_random(300, 86, 0);
		test_random(300, 0, 86);
		test_random(600, 11, 11);
		repeat (1000) @(negedge clk);
		$display("sent %0d items (load %0d compose %0d invert %0d point %0d), checked %0d",
			sent, op_count[0], op_count[1], op_count[2], op_count[3], checked);
		$display("results with singular %0d, with saturation %0d", sing_count, sat_count);
		if (errors == 0 && expected_results.size() == 0)
			$display("affine_2d_transform_unit verification clean");
		else
			$display("affine_2d_transform_unit verification failed");
		$finish;
	end
endmodule
`default_nettype wire
